FILE: rtl/core/rf_frontend_tuning_words_assert.svh
// Assertion macros for the tuning-word RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef RF_FRONTEND_TUNING_WORDS_ASSERT_SVH
`define RF_FRONTEND_TUNING_WORDS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define RFTW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rf_frontend_tuning_words: assertion failed");

// Next-cycle implication
`define RFTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rf_frontend_tuning_words: assertion failed");

`else

`define RFTW_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define RFTW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/rftw_pkg.sv
package rftw_pkg;

   // Frequency range
   localparam int unsigned HZ_W = 26;
   localparam logic [HZ_W-1:0] HZ_LIMIT = 26'd61440000;

   // Phase word: floor((hz*65536 + 937) / 1875), i.e. rounded hz*2^32/122.88e6
   localparam int unsigned PHASE_W      = 32;
   localparam int unsigned PHASE_DIVISOR = 1875;
   localparam int unsigned QUOT_HI_W    = 16;   // hz / 1875 <= 32768
   localparam int unsigned REM_W        = 11;   // remainder < 1875
   localparam int unsigned FRAC_X_W     = 27;   // remainder*65536 + 937
   localparam logic [FRAC_X_W-1:0] PHASE_ROUND_BIAS = 27'd937;

   // Reciprocal for the coarse quotient (exact for inputs below 2^26)
   localparam int unsigned RECIP_A_SHIFT = 37;
   localparam int unsigned RECIP_A_W     = 27;
   localparam logic [RECIP_A_W-1:0] RECIP_A =
      RECIP_A_W'(((64'd1 << RECIP_A_SHIFT) + 64'd1874) / 64'd1875);
   localparam int unsigned PROD_A_W = HZ_W + RECIP_A_W;

   // Reciprocal for the fractional quotient (exact for inputs below 2^27)
   localparam int unsigned RECIP_B_SHIFT = 38;
   localparam int unsigned RECIP_B_W     = 28;
   localparam logic [RECIP_B_W-1:0] RECIP_B =
      RECIP_B_W'(((64'd1 << RECIP_B_SHIFT) + 64'd1874) / 64'd1875);
   localparam int unsigned PROD_B_W = FRAC_X_W + RECIP_B_W;

   // Receive filter thresholds
   localparam logic [HZ_W-1:0] RX_LIM_BYPASS = 26'd1500000;
   localparam logic [HZ_W-1:0] RX_LIM_6M5    = 26'd6500000;
   localparam logic [HZ_W-1:0] RX_LIM_9M5    = 26'd9500000;
   localparam logic [HZ_W-1:0] RX_LIM_13M    = 26'd13000000;
   localparam logic [HZ_W-1:0] RX_LIM_20M    = 26'd20000000;
   localparam logic [HZ_W-1:0] RX_LIM_50M    = 26'd50000000;

   // Transmit low-pass thresholds
   localparam logic [HZ_W-1:0] TX_LIM_2M     = 26'd2000000;
   localparam logic [HZ_W-1:0] TX_LIM_4M     = 26'd4000000;
   localparam logic [HZ_W-1:0] TX_LIM_7M3    = 26'd7300000;
   localparam logic [HZ_W-1:0] TX_LIM_14M35  = 26'd14350000;
   localparam logic [HZ_W-1:0] TX_LIM_21M45  = 26'd21450000;
   localparam logic [HZ_W-1:0] TX_LIM_29M7   = 26'd29700000;

   // Filter word bit positions
   localparam int unsigned RX_BIT_BYPASS = 12;
   localparam int unsigned RX_BIT_6M5    = 6;
   localparam int unsigned RX_BIT_9M5    = 5;
   localparam int unsigned RX_BIT_13M    = 4;
   localparam int unsigned RX_BIT_20M    = 1;
   localparam int unsigned RX_BIT_50M    = 2;
   localparam int unsigned RX_BIT_HIGH   = 3;

   localparam int unsigned TX_BIT_2M     = 7;
   localparam int unsigned TX_BIT_4M     = 6;
   localparam int unsigned TX_BIT_7M3    = 5;
   localparam int unsigned TX_BIT_14M35  = 4;
   localparam int unsigned TX_BIT_21M45  = 15;
   localparam int unsigned TX_BIT_29M7   = 14;
   localparam int unsigned TX_BIT_HIGH   = 13;

   localparam int unsigned TX_BIT_ANT1   = 8;
   localparam int unsigned TX_BIT_ANT2   = 9;
   localparam int unsigned TX_BIT_ANT3   = 10;

   // Antenna register
   localparam int unsigned ANT_W = 2;
   localparam logic [ANT_W-1:0] ANT_1 = 2'd1;
   localparam logic [ANT_W-1:0] ANT_2 = 2'd2;
   localparam logic [ANT_W-1:0] ANT_3 = 2'd3;

   localparam int unsigned FILT_W = 16;

   typedef struct packed {
      logic [FILT_W-1:0] rx_word;
      logic [FILT_W-1:0] tx_word;
   } rftw_filter_type;

endpackage

FILE: rtl/core/rf_frontend_tuning_words.sv
// Results leave the stage 6 register on the rsp_ side in input order.
// Throughput: one item per cycle; the six-stage pipeline (two reciprocal
// multiplies, each with its own register) sets the depth, not the rate.
// A stalled output holds its stage; empty stages upstream still fill.
// Reset (synchronous, active high) clears all stage valid bits and sets the
// antenna register to 1. No clearing pass is needed.
module rf_frontend_tuning_words (
   input  logic                         clock,
   input  logic                         reset,
   // Input channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [rftw_pkg::HZ_W-1:0]    req_dial_hz,
   // Result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rftw_pkg::PHASE_W-1:0] rsp_phase_word,
   output logic [rftw_pkg::FILT_W-1:0]  rsp_rx_filter_word,
   output logic [rftw_pkg::FILT_W-1:0]  rsp_tx_filter_word,
   // Configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rftw_pkg::ANT_W-1:0]   csr_trx_antenna
);
   import rftw_pkg::*;

`include "rf_frontend_tuning_words_assert.svh"

   // Antenna register
   logic [ANT_W-1:0] antenna_ff;
   logic [ANT_W-1:0] antenna_in;

   assign csr_ready = 1'b1;

   always_comb begin
      antenna_in = antenna_ff;
      if (csr_valid && csr_ready) begin
         antenna_in = csr_trx_antenna;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         antenna_ff <= ANT_1;
      end else begin
         antenna_ff <= antenna_in;
      end
   end

   // Stage valid bits and per-stage advance
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6 = !v6_ff || !rsp_stall;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // Stage 1: saturate and pick the filter words
   logic [HZ_W-1:0]  hz_in;
   rftw_filter_type  filt_in;
   logic [HZ_W-1:0]  hz1_ff;
   rftw_filter_type  filt1_ff;

   assign hz_in = (req_dial_hz > HZ_LIMIT) ? HZ_LIMIT : req_dial_hz;

   rftw_band_select u_band_select (
      .hz      (hz_in),
      .antenna (antenna_ff),
      .words   (filt_in)
   );

   always_ff @(posedge clock) begin
      if (en1) begin
         hz1_ff   <= hz_in;
         filt1_ff <= filt_in;
      end
   end

   // Stage 2: coarse quotient product hz * (2^37 / 1875)
   logic [PROD_A_W-1:0] prod_a_in;
   logic [PROD_A_W-1:0] prod_a2_ff;
   logic [HZ_W-1:0]     hz2_ff;
   rftw_filter_type     filt2_ff;

   assign prod_a_in = PROD_A_W'(hz1_ff) * PROD_A_W'(RECIP_A);

   always_ff @(posedge clock) begin
      if (en2) begin
         prod_a2_ff <= prod_a_in;
         hz2_ff     <= hz1_ff;
         filt2_ff   <= filt1_ff;
      end
   end

   // Stage 3: coarse quotient hz / 1875
   logic [QUOT_HI_W-1:0] quot3_ff;
   logic [HZ_W-1:0]      hz3_ff;
   rftw_filter_type      filt3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         quot3_ff <= prod_a2_ff[RECIP_A_SHIFT +: QUOT_HI_W];
         hz3_ff   <= hz2_ff;
         filt3_ff <= filt2_ff;
      end
   end

   // Stage 4: remainder hz - quot * 1875
   logic [HZ_W-1:0]      quot_scaled;
   logic [HZ_W-1:0]      rem_full;
   logic [REM_W-1:0]     rem4_ff;
   logic [QUOT_HI_W-1:0] quot4_ff;
   rftw_filter_type      filt4_ff;

   assign quot_scaled = HZ_W'(quot3_ff) * HZ_W'(PHASE_DIVISOR);
   assign rem_full    = hz3_ff - quot_scaled;

   always_ff @(posedge clock) begin
      if (en4) begin
         rem4_ff  <= rem_full[REM_W-1:0];
         quot4_ff <= quot3_ff;
         filt4_ff <= filt3_ff;
      end
   end

   // Stage 5: fractional product (rem*65536 + 937) * (2^38 / 1875)
   logic [FRAC_X_W-1:0]  frac_x;
   logic [PROD_B_W-1:0]  prod_b_in;
   logic [PROD_B_W-1:0]  prod_b5_ff;
   logic [QUOT_HI_W-1:0] quot5_ff;
   rftw_filter_type      filt5_ff;

   assign frac_x    = {rem4_ff, {QUOT_HI_W{1'b0}}} + PHASE_ROUND_BIAS;
   assign prod_b_in = PROD_B_W'(frac_x) * PROD_B_W'(RECIP_B);

   always_ff @(posedge clock) begin
      if (en5) begin
         prod_b5_ff <= prod_b_in;
         quot5_ff   <= quot4_ff;
         filt5_ff   <= filt4_ff;
      end
   end

   // Stage 6: output register; low half is the fractional quotient (< 65536)
   logic [PHASE_W-1:0] phase6_ff;
   rftw_filter_type    filt6_ff;

   always_ff @(posedge clock) begin
      if (en6) begin
         phase6_ff <= {quot5_ff, prod_b5_ff[RECIP_B_SHIFT +: QUOT_HI_W]};
         filt6_ff  <= filt5_ff;
      end
   end

   assign rsp_valid          = v6_ff;
   assign rsp_phase_word     = phase6_ff;
   assign rsp_rx_filter_word = filt6_ff.rx_word;
   assign rsp_tx_filter_word = filt6_ff.tx_word;

   // Checks
   `RFTW_ASSERT_IMPLIES(a_quot_range, clock, reset, v3_ff, quot3_ff <= 16'd32768)
   `RFTW_ASSERT_IMPLIES(a_rem_range, clock, reset, v4_ff, rem4_ff < 11'd1875)
   `RFTW_ASSERT_IMPLIES(a_phase_range, clock, reset, rsp_valid,
                        rsp_phase_word <= 32'h8000_0000)
   `RFTW_ASSERT_IMPLIES(a_rx_onehot, clock, reset, rsp_valid, $onehot(rsp_rx_filter_word))
   `RFTW_ASSERT_IMPLIES(a_tx_two_bits, clock, reset, rsp_valid,
                        $countones(rsp_tx_filter_word) == 2)
   `RFTW_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, v1_ff)

endmodule

FILE: rtl/core/rftw_band_select.sv
module rftw_band_select (
   input  logic [rftw_pkg::HZ_W-1:0]  hz,
   input  logic [rftw_pkg::ANT_W-1:0] antenna,
   output rftw_pkg::rftw_filter_type  words
);
   import rftw_pkg::*;

   logic [FILT_W-1:0] rx_word;
   logic [FILT_W-1:0] lpf_word;
   logic [FILT_W-1:0] ant_word;

   // Receive band-pass / high-pass select
   always_comb begin
      rx_word = '0;
      if (hz < RX_LIM_BYPASS) begin
         rx_word[RX_BIT_BYPASS] = 1'b1;
      end else if (hz < RX_LIM_6M5) begin
         rx_word[RX_BIT_6M5] = 1'b1;
      end else if (hz < RX_LIM_9M5) begin
         rx_word[RX_BIT_9M5] = 1'b1;
      end else if (hz < RX_LIM_13M) begin
         rx_word[RX_BIT_13M] = 1'b1;
      end else if (hz < RX_LIM_20M) begin
         rx_word[RX_BIT_20M] = 1'b1;
      end else if (hz < RX_LIM_50M) begin
         rx_word[RX_BIT_50M] = 1'b1;
      end else begin
         rx_word[RX_BIT_HIGH] = 1'b1;
      end
   end

   // Transmit low-pass select
   always_comb begin
      lpf_word = '0;
      if (hz < TX_LIM_2M) begin
         lpf_word[TX_BIT_2M] = 1'b1;
      end else if (hz < TX_LIM_4M) begin
         lpf_word[TX_BIT_4M] = 1'b1;
      end else if (hz < TX_LIM_7M3) begin
         lpf_word[TX_BIT_7M3] = 1'b1;
      end else if (hz < TX_LIM_14M35) begin
         lpf_word[TX_BIT_14M35] = 1'b1;
      end else if (hz < TX_LIM_21M45) begin
         lpf_word[TX_BIT_21M45] = 1'b1;
      end else if (hz < TX_LIM_29M7) begin
         lpf_word[TX_BIT_29M7] = 1'b1;
      end else begin
         lpf_word[TX_BIT_HIGH] = 1'b1;
      end
   end

   // Antenna route; zero falls back to antenna 1
   always_comb begin
      ant_word = '0;
      case (antenna)
         ANT_2:   ant_word[TX_BIT_ANT2] = 1'b1;
         ANT_3:   ant_word[TX_BIT_ANT3] = 1'b1;
         default: ant_word[TX_BIT_ANT1] = 1'b1;
      endcase
   end

   assign words.rx_word = rx_word;
   assign words.tx_word = lpf_word | ant_word;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rftw_pkg::*;

   // Phase word: floor((hz * 2^17 + 1875) / 3750)
   localparam logic [63:0] PHASE_SCALE = 64'd131072;
   localparam logic [63:0] PHASE_ROUND = 64'd1875;
   localparam logic [63:0] PHASE_DIV   = 64'd3750;
   localparam logic [ANT_W-1:0] ANT_0  = 2'd0;   // falls back to antenna 1 route
   localparam int DRAIN_CYCLES = 12;              // quiet cycles at the end of each drain
   localparam int ITEMS_PER_PHASE = 125;
   localparam int NUM_PHASES = 6;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_word;
      logic [FILT_W-1:0]  rx_word;
      logic [FILT_W-1:0]  tx_word;
   } tuning_type;

   typedef struct packed {
      logic [HZ_W-1:0] hz;
      logic            known;
      tuning_type      typed;
   } dial_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [HZ_W-1:0]      req_dial_hz = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PHASE_W-1:0]   rsp_phase_word;
   logic [FILT_W-1:0]    rsp_rx_filter_word;
   logic [FILT_W-1:0]    rsp_tx_filter_word;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [ANT_W-1:0]     csr_trx_antenna = ANT_1;

   tuning_type           tuning_expected [$];
   dial_row_type         dial_table [$];
   logic [HZ_W-1:0]      band_edges [13];
   logic [ANT_W-1:0]     antenna_plan [NUM_PHASES];
   logic [ANT_W-1:0]     antenna_setting = ANT_1;
   int                   idle_pct = 28;
   int                   mismatch_count = 0;

   rf_frontend_tuning_words dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_dial_hz        (req_dial_hz),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_phase_word     (rsp_phase_word),
      .rsp_rx_filter_word (rsp_rx_filter_word),
      .rsp_tx_filter_word (rsp_tx_filter_word),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_trx_antenna    (csr_trx_antenna)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the pipeline hangs
   initial begin
      #1000000;
      $display("tb_top: done, errors");
      $finish;
   end

   // Tuning words for one dial frequency under the given antenna setting
   function automatic tuning_type predict_tuning(input logic [HZ_W-1:0] dial,
                                                 input logic [ANT_W-1:0] ant);
      logic [HZ_W-1:0] hz;
      logic [63:0]     scaled;
      tuning_type      t;
      hz = (dial > HZ_LIMIT) ? HZ_LIMIT : dial;
      scaled = ({38'd0, hz} * PHASE_SCALE + PHASE_ROUND) / PHASE_DIV;
      t.phase_word = scaled[PHASE_W-1:0];

      t.rx_word = '0;
      if (hz < RX_LIM_BYPASS)    t.rx_word[RX_BIT_BYPASS] = 1'b1;
      else if (hz < RX_LIM_6M5)  t.rx_word[RX_BIT_6M5]    = 1'b1;
      else if (hz < RX_LIM_9M5)  t.rx_word[RX_BIT_9M5]    = 1'b1;
      else if (hz < RX_LIM_13M)  t.rx_word[RX_BIT_13M]    = 1'b1;
      else if (hz < RX_LIM_20M)  t.rx_word[RX_BIT_20M]    = 1'b1;
      else if (hz < RX_LIM_50M)  t.rx_word[RX_BIT_50M]    = 1'b1;
      else                       t.rx_word[RX_BIT_HIGH]   = 1'b1;

      t.tx_word = '0;
      if (hz < TX_LIM_2M)          t.tx_word[TX_BIT_2M]    = 1'b1;
      else if (hz < TX_LIM_4M)     t.tx_word[TX_BIT_4M]    = 1'b1;
      else if (hz < TX_LIM_7M3)    t.tx_word[TX_BIT_7M3]   = 1'b1;
      else if (hz < TX_LIM_14M35)  t.tx_word[TX_BIT_14M35] = 1'b1;
      else if (hz < TX_LIM_21M45)  t.tx_word[TX_BIT_21M45] = 1'b1;
      else if (hz < TX_LIM_29M7)   t.tx_word[TX_BIT_29M7]  = 1'b1;
      else                         t.tx_word[TX_BIT_HIGH]  = 1'b1;

      // antenna route; zero takes the default route
      case (ant)
         ANT_2:   t.tx_word[TX_BIT_ANT2] = 1'b1;
         ANT_3:   t.tx_word[TX_BIT_ANT3] = 1'b1;
         default: t.tx_word[TX_BIT_ANT1] = 1'b1;
      endcase
      return t;
   endfunction

   // Random dial: in band, near a switch point, above the limit, or any 26 bits
   function automatic logic [HZ_W-1:0] pick_dial();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40)
         return HZ_W'($urandom_range(0, HZ_LIMIT));
      else if (sel < 70)
         return band_edges[$urandom_range(0, 12)] + HZ_W'($urandom_range(0, 64)) - HZ_W'(32);
      else if (sel < 85)
         return HZ_W'($urandom_range(HZ_LIMIT, (1 << HZ_W) - 1));
      else
         return HZ_W'($urandom);
   endfunction

   // One input transfer; valid stays up between back-to-back items
   task automatic send_dial(input logic [HZ_W-1:0] hz, input tuning_type want);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_dial_hz <= hz;
      do @(posedge clock); while (req_stall);
      tuning_expected.push_back(want);
   endtask

   // Let every outstanding result come back, then a few quiet cycles
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tuning_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_antenna(input logic [ANT_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_trx_antenna <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      antenna_setting = value;
   endtask

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < idle_pct);
   end

   // Result checker: each transfer against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      tuning_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tuning_expected.size() == 0) begin
            $display("%0t: result with nothing expected: phase=%h rx=%h tx=%h", $time,
                     rsp_phase_word, rsp_rx_filter_word, rsp_tx_filter_word);
            mismatch_count++;
         end else begin
            want = tuning_expected.pop_front();
            if (rsp_phase_word !== want.phase_word) begin
               $display("%0t: phase_word expected %h got %h", $time,
                        want.phase_word, rsp_phase_word);
               mismatch_count++;
            end
            if (rsp_rx_filter_word !== want.rx_word) begin
               $display("%0t: rx_filter_word expected %h got %h", $time,
                        want.rx_word, rsp_rx_filter_word);
               mismatch_count++;
            end
            if (rsp_tx_filter_word !== want.tx_word) begin
               $display("%0t: tx_filter_word expected %h got %h", $time,
                        want.tx_word, rsp_tx_filter_word);
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      tuning_type want;
      int         p;
      int         n;

      band_edges = '{RX_LIM_BYPASS, RX_LIM_6M5, RX_LIM_9M5, RX_LIM_13M, RX_LIM_20M,
                     RX_LIM_50M, TX_LIM_2M, TX_LIM_4M, TX_LIM_7M3, TX_LIM_14M35,
                     TX_LIM_21M45, TX_LIM_29M7, HZ_LIMIT};
      antenna_plan = '{ANT_2, ANT_3, ANT_0, ANT_1, ANT_2, ANT_3};

      // Directed rows at the reset antenna (1). Typed values:
      // zero -> phase 0, rx bypass, tx 2 MHz low-pass + antenna 1;
      // at or above the limit -> phase 2^31, rx top band, tx top low-pass + antenna 1.
      dial_table.push_back('{HZ_W'(0), 1'b1, '{32'h0000_0000, 16'h1000, 16'h0180}});
      dial_table.push_back('{HZ_W'(1), 1'b0, '0});
      dial_table.push_back('{HZ_W'(1499999), 1'b0, '0});
      dial_table.push_back('{RX_LIM_BYPASS, 1'b0, '0});
      dial_table.push_back('{TX_LIM_2M, 1'b0, '0});
      dial_table.push_back('{TX_LIM_4M, 1'b0, '0});
      dial_table.push_back('{RX_LIM_6M5, 1'b0, '0});
      dial_table.push_back('{TX_LIM_7M3, 1'b0, '0});
      dial_table.push_back('{RX_LIM_9M5, 1'b0, '0});
      dial_table.push_back('{RX_LIM_13M, 1'b0, '0});
      dial_table.push_back('{TX_LIM_14M35, 1'b0, '0});
      dial_table.push_back('{RX_LIM_20M, 1'b0, '0});
      dial_table.push_back('{TX_LIM_21M45, 1'b0, '0});
      dial_table.push_back('{HZ_W'(29699999), 1'b0, '0});
      dial_table.push_back('{TX_LIM_29M7, 1'b0, '0});
      dial_table.push_back('{RX_LIM_50M, 1'b0, '0});
      dial_table.push_back('{HZ_W'(61439999), 1'b0, '0});
      dial_table.push_back('{HZ_LIMIT, 1'b1, '{32'h8000_0000, 16'h0008, 16'h2100}});
      // above the limit saturates
      dial_table.push_back('{HZ_LIMIT + HZ_W'(1), 1'b1, '{32'h8000_0000, 16'h0008, 16'h2100}});
      dial_table.push_back('{{HZ_W{1'b1}}, 1'b1, '{32'h8000_0000, 16'h0008, 16'h2100}});

      // reset held, then released before the directed rows
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dial_table[i]) begin
         if (dial_table[i].known)
            want = dial_table[i].typed;
         else
            want = predict_tuning(dial_table[i].hz, antenna_setting);
         send_dial(dial_table[i].hz, want);
      end
      drain_results();

      // Random phases, each under its own antenna setting; the second runs unthrottled
      for (p = 0; p < NUM_PHASES; p++) begin
         if (p == NUM_PHASES - 2)
            write_antenna(ANT_W'($urandom_range(0, 3)));
         else
            write_antenna(antenna_plan[p]);
         idle_pct = (p == 1) ? 0 : 28;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            want = '0;
            req_dial_hz_pick: begin
               logic [HZ_W-1:0] hz;
               hz = pick_dial();
               send_dial(hz, predict_tuning(hz, antenna_setting));
            end
         end
         drain_results();
      end

      if (mismatch_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/rftw_pkg.sv
rtl/core/rftw_band_select.sv
rtl/core/rf_frontend_tuning_words.sv
bench/tb_top.sv
